/* rtl/sitda_pkg.sv */
// Shared constants and helpers for the signed integer to decimal text core.
package sitda_pkg;

  // Default width of the incoming two's complement value
  localparam int VALUE_BITS_DEF = 32;

  // Depth of the queue between the front and back parts
  localparam int QUEUE_DEPTH = 2;

  // ASCII codes produced on the result side
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // Decimal digits needed for a magnitude of up to bits bits (log10(2) ~ 0.30103)
  function automatic int num_digits(input int bits);
    num_digits = (bits * 30103) / 100000 + 1;
  endfunction

endpackage

/* rtl/sitda_front.sv */
// Front part: takes a value, splits it into sign and unsigned magnitude.
module sitda_front #(
  parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  in_full,
  output logic                  q_push,
  output logic [VALUE_BITS:0]   q_data,
  input  logic                  q_full
);

  logic                  vld_r;
  logic                  vld_nxt;
  logic                  neg_r;
  logic [VALUE_BITS-1:0] mag_r;
  logic                  take;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;

  // Hand the held word to the queue whenever it has room
  assign q_push  = vld_r && !q_full;
  assign q_data  = {neg_r, mag_r};
  assign in_full = vld_r && q_full;
  assign take    = in_push && !in_full;

  // Form the magnitude as unsigned so the most negative value stays exact
  assign in_neg = in_value[VALUE_BITS-1];
  assign in_mag = in_neg ? (~in_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : in_value;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (q_push) begin
      vld_nxt = 1'b0;
    end
  end

  // Hold control under reset, payload without
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      neg_r <= in_neg;
      mag_r <= in_mag;
    end
  end

endmodule

/* rtl/sitda_fifo.sv */
// Small register queue between the front and back parts.
module sitda_fifo #(
  parameter int WIDTH = sitda_pkg::VALUE_BITS_DEF + 1,
  parameter int DEPTH = sitda_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r;
  logic [PW-1:0]    wptr_nxt;
  logic [PW-1:0]    rptr_r;
  logic [PW-1:0]    rptr_nxt;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

/* rtl/sitda_back.sv */
// Back part: shift-and-add-3 conversion to decimal digits, then character output.
module sitda_back #(
  parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  logic [VALUE_BITS:0]   q_data,
  output logic                  q_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [7:0]            out_text_char,
  output logic                  out_is_last
);

  localparam int NDIG = sitda_pkg::num_digits(VALUE_BITS);
  localparam int BW   = NDIG * 4;
  localparam int CW   = $clog2(VALUE_BITS + 1);
  localparam int DW   = $clog2(NDIG + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t                st_r,   st_nxt;
  logic [BW-1:0]         bcd_r,  bcd_nxt;
  logic [VALUE_BITS-1:0] sh_r,   sh_nxt;
  logic [CW-1:0]         cnt_r,  cnt_nxt;
  logic [DW-1:0]         dig_r,  dig_nxt;
  logic                  neg_r,  neg_nxt;
  logic                  ovld_r, ovld_nxt;
  logic [7:0]            ochr_r, ochr_nxt;
  logic                  olst_r, olst_nxt;
  logic [BW-1:0]         bcd_adj;
  logic [3:0]            top_dig;
  logic                  out_free;

  assign out_empty     = !ovld_r;
  assign out_text_char = ochr_r;
  assign out_is_last   = olst_r;
  assign out_free      = !ovld_r || out_pop;
  assign top_dig       = bcd_r[BW-1 -: 4];

  // Add 3 to every digit of 5 or more before the next shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                     : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    st_nxt   = st_r;
    bcd_nxt  = bcd_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    dig_nxt  = dig_r;
    neg_nxt  = neg_r;
    ovld_nxt = ovld_r;
    ochr_nxt = ochr_r;
    olst_nxt = olst_r;
    q_pop    = 1'b0;
    // Drop the output word once it is taken
    if (out_pop && ovld_r) begin
      ovld_nxt = 1'b0;
    end
    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          neg_nxt = q_data[VALUE_BITS];
          sh_nxt  = q_data[VALUE_BITS-1:0];
          bcd_nxt = '0;
          cnt_nxt = CW'(VALUE_BITS);
          st_nxt  = ST_CONV;
        end
      end
      // Shift one magnitude bit into the digits per cycle
      ST_CONV: begin
        bcd_nxt = {bcd_adj[BW-2:0], sh_r[VALUE_BITS-1]};
        sh_nxt  = {sh_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          dig_nxt = DW'(NDIG);
          st_nxt  = ST_SKIP;
        end
      end
      // Drop leading zero digits, keeping at least one
      ST_SKIP: begin
        if (top_dig == 4'd0 && dig_r != DW'(1)) begin
          bcd_nxt = {bcd_r[BW-5:0], 4'd0};
          dig_nxt = dig_r - DW'(1);
        end else begin
          st_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          ovld_nxt = 1'b1;
          ochr_nxt = sitda_pkg::CHAR_MINUS;
          olst_nxt = 1'b0;
          st_nxt   = ST_EMIT;
        end
      end
      // Send one digit per free output slot, most significant first
      ST_EMIT: begin
        if (out_free) begin
          ovld_nxt = 1'b1;
          ochr_nxt = sitda_pkg::CHAR_ZERO + {4'd0, top_dig};
          olst_nxt = (dig_r == DW'(1));
          bcd_nxt  = {bcd_r[BW-5:0], 4'd0};
          dig_nxt  = dig_r - DW'(1);
          if (dig_r == DW'(1)) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ovld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ovld_r <= ovld_nxt;
    end
    bcd_r  <= bcd_nxt;
    sh_r   <= sh_nxt;
    cnt_r  <= cnt_nxt;
    dig_r  <= dig_nxt;
    neg_r  <= neg_nxt;
    ochr_r <= ochr_nxt;
    olst_r <= olst_nxt;
  end

endmodule

/* rtl/signed_int_to_decimal_ascii_core.sv */
// Top level: signed integer to decimal ASCII text, one character per word.
//
//   channel  direction  handshake          payload
//   in_      input      in_push / in_full   in_value (VALUE_BITS, signed)
//   out_     output     out_pop / out_empty out_text_char (8), out_is_last (1)
//
// A value passes the front register and the queue before the converter pops it. The converter shifts
// VALUE_BITS magnitude bits into NDIG decimal digits one per cycle, drops leading zero digits
// one per cycle, then sends the sign and one digit per cycle while the output is free.
// Reset (rst_n low, synchronous) empties the queue and the output register.
// A stalled out_pop holds the current character and pauses the sign and digit output only.
module signed_int_to_decimal_ascii_core #(
  parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [7:0]            out_text_char,
  output logic                  out_is_last
);

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;
  logic [VALUE_BITS:0] q_wdata;
  logic [VALUE_BITS:0] q_rdata;

  sitda_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_value (in_value),
    .in_full  (in_full),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  sitda_fifo #(
    .WIDTH (VALUE_BITS + 1),
    .DEPTH (sitda_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  sitda_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_text_char (out_text_char),
    .out_is_last   (out_is_last)
  );

endmodule
